// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define LNRT_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LNRT_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lnrt_pkg.sv =====
package lnrt_pkg;

   // Field widths of the channels.
   localparam int FUNC_W     = 2;
   localparam int ID_W       = 32;
   localparam int LEVEL_W    = 8;
   localparam int CHAN_W     = 8;
   localparam int CONG_W     = 6;
   localparam int REG_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [LEVEL_W-1:0] level_type;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_ENTRY    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SCAN_END = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART  = 2'd2;

   // Configuration register indexes.
   localparam logic [REG_IDX_W-1:0] REG_TRACK_EN   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_TARGET_ID  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_START_CHAN = 2'd2;

   // Signal levels and limits.
   localparam level_type NO_SIGNAL  = -8'sd120;
   localparam level_type STAT_RESET = -8'sd100;
   localparam int OVERLAP_SPAN = 2;
   localparam logic [CONG_W-1:0] CONGEST_CAP = 6'd63;

endpackage

// ===== src/lnrt_if.sv =====
// Scan request channel.
interface lnrt_req_if import lnrt_pkg::*;;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [ID_W-1:0]     network_id;
   logic signed [LEVEL_W-1:0] rssi;
   logic [CHAN_W-1:0]   channel;
   logic                last_in_scan;

   modport source (output valid, func, network_id, rssi, channel, last_in_scan,
                   input ready);
   modport sink (input valid, func, network_id, rssi, channel, last_in_scan,
                 output ready);
endinterface

// Scan report channel.
interface lnrt_rsp_if import lnrt_pkg::*;;
   logic                valid;
   logic                ready;
   logic                found;
   logic signed [LEVEL_W-1:0] raw_rssi;
   logic signed [LEVEL_W-1:0] smoothed_rssi;
   logic signed [LEVEL_W-1:0] min_rssi;
   logic signed [LEVEL_W-1:0] max_rssi;
   logic [CONG_W-1:0]   congestion_count;
   logic signed [LEVEL_W-1:0] strongest_interferer;

   modport source (output valid, found, raw_rssi, smoothed_rssi, min_rssi, max_rssi,
                   congestion_count, strongest_interferer, input ready);
   modport sink (input valid, found, raw_rssi, smoothed_rssi, min_rssi, max_rssi,
                 congestion_count, strongest_interferer, output ready);
endinterface

// Configuration write channel.
interface lnrt_csr_if import lnrt_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [REG_IDX_W-1:0]  addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// ===== src/lnrt_ram.sv =====
module lnrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/locked_network_rssi_tracker.sv =====
// With tracking on, a plain scan entry is taken in S_IDLE; a scan end without the target
// goes to S_EMIT; one with the target passes S_WRITE, S_SWEEP, S_DRAIN, S_DIVINIT, S_DIV
// and S_UPDATE first. S_EMIT loads the report once the output register is free.
// Throughput: one request per cycle for plain entries while idle; a scan end is set by the
// window RAM sweep (one entry per cycle), bit-serial divider (one quotient bit per cycle).
// Reset is synchronous and active high; it clears all statistics and window valid bits.
module locked_network_rssi_tracker import lnrt_pkg::*; #(
   parameter int WINDOW_LEN  = 8,
   parameter int MAX_ENTRIES = 32
) (
   input  logic       clock,
   input  logic       reset,
   lnrt_req_if.sink   req_bus,
   lnrt_rsp_if.source rsp_bus,
   lnrt_csr_if.sink   csr_bus
);

   localparam int AW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int MAG_W = $clog2(WINDOW_LEN * 128 + 1);
   localparam int SUM_W = MAG_W + 1;
   localparam int ENT_W = $clog2(MAX_ENTRIES + 1);
   localparam int DC_W  = $clog2(MAG_W + 1);
   localparam logic [AW-1:0]     LAST_IDX  = AW'(WINDOW_LEN - 1);
   localparam logic [DC_W-1:0]   LAST_STEP = DC_W'(MAG_W - 1);
   localparam logic [ENT_W-1:0]  ENT_LIMIT = ENT_W'(MAX_ENTRIES);
   localparam logic signed [CHAN_W:0] SPAN_POS = (CHAN_W + 1)'(OVERLAP_SPAN);
   localparam logic signed [CHAN_W:0] SPAN_NEG = -SPAN_POS;

   typedef enum logic [2:0] {
      S_IDLE, S_WRITE, S_SWEEP, S_DRAIN, S_DIVINIT, S_DIV, S_UPDATE, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic              track_en_ff, track_en_in;
   logic [ID_W-1:0]   target_id_ff, target_id_in;
   logic [CHAN_W-1:0] start_ch_ff, start_ch_in;

   // Per-scan accumulators.
   logic [CHAN_W-1:0] tracked_ch_ff, tracked_ch_in;
   logic              scan_found_ff, scan_found_in;
   level_type         scan_rssi_ff, scan_rssi_in;
   logic [CONG_W-1:0] scan_cong_ff, scan_cong_in;
   level_type         scan_strong_ff, scan_strong_in;
   logic [ENT_W-1:0]  scan_cnt_ff, scan_cnt_in;

   // Statistics.
   level_type raw_ff, raw_in;
   level_type smooth_ff, smooth_in;
   level_type min_ff, min_in;
   level_type max_ff, max_in;
   logic [WINDOW_LEN-1:0] win_valid_ff, win_valid_in;
   logic [AW-1:0]         win_idx_ff, win_idx_in;

   // Window sweep and divider.
   logic [AW-1:0]           sweep_idx_ff, sweep_idx_in;
   logic                    rd_live_ff, rd_live_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        num_ff, num_in;
   logic [CNT_W:0]          div_rem_ff, div_rem_in;
   logic [MAG_W-1:0]        div_quo_ff, div_quo_in;
   logic [DC_W-1:0]         div_cnt_ff, div_cnt_in;
   logic                    div_neg_ff, div_neg_in;

   // Report register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   level_type         rsp_raw_ff, rsp_raw_in;
   level_type         rsp_smooth_ff, rsp_smooth_in;
   level_type         rsp_min_ff, rsp_min_in;
   level_type         rsp_max_ff, rsp_max_in;
   logic [CONG_W-1:0] rsp_cong_ff, rsp_cong_in;
   level_type         rsp_strong_ff, rsp_strong_in;

   // Window RAM ports.
   logic           ram_wr_en;
   logic           ram_rd_en;
   logic [7:0]     ram_rd_data;

   logic                    req_take;
   logic                    is_target;
   logic signed [CHAN_W:0]  ch_diff;
   logic                    near;
   logic [CNT_W:0]          rem_shift;
   logic                    quo_bit;
   logic [SUM_W-1:0]        sum_neg;
   logic [LEVEL_W:0]        quo_signed;
   level_type               avg;

   lnrt_ram #(.WIDTH(LEVEL_W), .DEPTH(WINDOW_LEN)) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (win_idx_ff),
      .wr_data (scan_rssi_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (sweep_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign ram_wr_en     = (state_ff == S_WRITE);
   assign ram_rd_en     = (state_ff == S_SWEEP);

   // Entry classification against the target id and the tracked channel.
   assign is_target = (req_bus.network_id == target_id_ff);
   assign ch_diff   = $signed({1'b0, req_bus.channel}) - $signed({1'b0, tracked_ch_ff});
   assign near      = (ch_diff >= SPAN_NEG) && (ch_diff <= SPAN_POS);

   // One restoring division step on the window sum magnitude.
   assign rem_shift = {div_rem_ff[CNT_W-1:0], div_quo_ff[MAG_W-1]};
   assign quo_bit   = (rem_shift >= {1'b0, num_ff});
   assign sum_neg   = -sum_ff;

   // Signed average; the quotient magnitude never exceeds 128.
   assign quo_signed = div_neg_ff ? -{1'b0, div_quo_ff[LEVEL_W-1:0]}
                                  : {1'b0, div_quo_ff[LEVEL_W-1:0]};
   assign avg = (num_ff == '0) ? level_type'(0) : level_type'(quo_signed[LEVEL_W-1:0]);

   always_comb begin
      state_in       = state_ff;
      track_en_in    = track_en_ff;
      target_id_in   = target_id_ff;
      start_ch_in    = start_ch_ff;
      tracked_ch_in  = tracked_ch_ff;
      scan_found_in  = scan_found_ff;
      scan_rssi_in   = scan_rssi_ff;
      scan_cong_in   = scan_cong_ff;
      scan_strong_in = scan_strong_ff;
      scan_cnt_in    = scan_cnt_ff;
      raw_in         = raw_ff;
      smooth_in      = smooth_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      win_valid_in   = win_valid_ff;
      win_idx_in     = win_idx_ff;
      sweep_idx_in   = sweep_idx_ff;
      rd_live_in     = (state_ff == S_SWEEP);
      rd_valid_in    = win_valid_ff[sweep_idx_ff];
      sum_in         = sum_ff;
      num_in         = num_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      div_cnt_in     = div_cnt_ff;
      div_neg_in     = div_neg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_raw_in     = rsp_raw_ff;
      rsp_smooth_in  = rsp_smooth_ff;
      rsp_min_in     = rsp_min_ff;
      rsp_max_in     = rsp_max_ff;
      rsp_cong_in    = rsp_cong_ff;
      rsp_strong_in  = rsp_strong_ff;

      // Configuration writes.
      if (csr_bus.valid) begin
         case (csr_bus.addr)
            REG_TRACK_EN:   track_en_in  = csr_bus.data[0];
            REG_TARGET_ID:  target_id_in = csr_bus.data[ID_W-1:0];
            REG_START_CHAN: start_ch_in  = csr_bus.data[CHAN_W-1:0];
            default: ;
         endcase
      end

      // Window read data arrives in the cycle after the address.
      if (rd_live_ff && rd_valid_ff && (ram_rd_data != '0)) begin
         sum_in = sum_ff + {{(SUM_W - LEVEL_W){ram_rd_data[LEVEL_W-1]}}, ram_rd_data};
         num_in = num_ff + CNT_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_bus.func)
                  FUNC_RESTART: begin
                     tracked_ch_in  = start_ch_ff;
                     raw_in         = STAT_RESET;
                     smooth_in      = STAT_RESET;
                     min_in         = '0;
                     max_in         = STAT_RESET;
                     win_valid_in   = '0;
                     win_idx_in     = '0;
                     scan_found_in  = 1'b0;
                     scan_rssi_in   = NO_SIGNAL;
                     scan_cong_in   = '0;
                     scan_strong_in = NO_SIGNAL;
                     scan_cnt_in    = '0;
                  end
                  FUNC_SCAN_END: begin
                     if (!track_en_ff) begin
                        scan_found_in  = 1'b0;
                        scan_rssi_in   = NO_SIGNAL;
                        scan_cong_in   = '0;
                        scan_strong_in = NO_SIGNAL;
                        scan_cnt_in    = '0;
                     end else begin
                        state_in = scan_found_ff ? S_WRITE : S_EMIT;
                     end
                  end
                  FUNC_ENTRY: begin
                     if (!track_en_ff) begin
                        scan_found_in  = 1'b0;
                        scan_rssi_in   = NO_SIGNAL;
                        scan_cong_in   = '0;
                        scan_strong_in = NO_SIGNAL;
                        scan_cnt_in    = '0;
                     end else begin
                        // Entries past the per-scan limit are dropped.
                        if (scan_cnt_ff < ENT_LIMIT) begin
                           scan_cnt_in = scan_cnt_ff + ENT_W'(1);
                           if (is_target) begin
                              scan_found_in = 1'b1;
                              scan_rssi_in  = req_bus.rssi;
                              tracked_ch_in = req_bus.channel;
                           end else if ((tracked_ch_ff != '0) && near) begin
                              if (scan_cong_ff != CONGEST_CAP) begin
                                 scan_cong_in = scan_cong_ff + CONG_W'(1);
                              end
                              if (req_bus.rssi > scan_strong_ff) begin
                                 scan_strong_in = req_bus.rssi;
                              end
                           end
                        end
                        if (req_bus.last_in_scan) begin
                           state_in = scan_found_in ? S_WRITE : S_EMIT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_WRITE: begin
            // The RAM takes the new level; the sweep starts next cycle.
            win_valid_in[win_idx_ff] = 1'b1;
            win_idx_in   = (win_idx_ff == LAST_IDX) ? '0 : win_idx_ff + AW'(1);
            sweep_idx_in = '0;
            sum_in       = '0;
            num_in       = '0;
            state_in     = S_SWEEP;
         end
         S_SWEEP: begin
            sweep_idx_in = sweep_idx_ff + AW'(1);
            if (sweep_idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DIVINIT;
         end
         S_DIVINIT: begin
            div_neg_in = sum_ff[SUM_W-1];
            div_quo_in = sum_ff[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_ff[MAG_W-1:0];
            div_rem_in = '0;
            div_cnt_in = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            div_rem_in = quo_bit ? rem_shift - {1'b0, num_ff} : rem_shift;
            div_quo_in = {div_quo_ff[MAG_W-2:0], quo_bit};
            div_cnt_in = div_cnt_ff + DC_W'(1);
            if (div_cnt_ff == LAST_STEP) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // A min of zero means it has not been set yet.
            raw_in    = scan_rssi_ff;
            smooth_in = avg;
            if ((avg < min_ff) || (min_ff == '0)) begin
               min_in = avg;
            end
            if (avg > max_ff) begin
               max_in = avg;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Load the report once the output register is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = scan_found_ff;
               rsp_raw_in     = raw_ff;
               rsp_smooth_in  = smooth_ff;
               rsp_min_in     = min_ff;
               rsp_max_in     = max_ff;
               rsp_cong_in    = scan_cong_ff;
               rsp_strong_in  = scan_strong_ff;
               scan_found_in  = 1'b0;
               scan_rssi_in   = NO_SIGNAL;
               scan_cong_in   = '0;
               scan_strong_in = NO_SIGNAL;
               scan_cnt_in    = '0;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, statistics and report registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         track_en_ff    <= 1'b0;
         target_id_ff   <= '0;
         start_ch_ff    <= '0;
         tracked_ch_ff  <= '0;
         scan_found_ff  <= 1'b0;
         scan_rssi_ff   <= NO_SIGNAL;
         scan_cong_ff   <= '0;
         scan_strong_ff <= NO_SIGNAL;
         scan_cnt_ff    <= '0;
         raw_ff         <= STAT_RESET;
         smooth_ff      <= STAT_RESET;
         min_ff         <= '0;
         max_ff         <= STAT_RESET;
         win_valid_ff   <= '0;
         win_idx_ff     <= '0;
         rd_live_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         track_en_ff    <= track_en_in;
         target_id_ff   <= target_id_in;
         start_ch_ff    <= start_ch_in;
         tracked_ch_ff  <= tracked_ch_in;
         scan_found_ff  <= scan_found_in;
         scan_rssi_ff   <= scan_rssi_in;
         scan_cong_ff   <= scan_cong_in;
         scan_strong_ff <= scan_strong_in;
         scan_cnt_ff    <= scan_cnt_in;
         raw_ff         <= raw_in;
         smooth_ff      <= smooth_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         win_valid_ff   <= win_valid_in;
         win_idx_ff     <= win_idx_in;
         rd_live_ff     <= rd_live_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      sweep_idx_ff  <= sweep_idx_in;
      rd_valid_ff   <= rd_valid_in;
      sum_ff        <= sum_in;
      num_ff        <= num_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_cnt_ff    <= div_cnt_in;
      div_neg_ff    <= div_neg_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_smooth_ff <= rsp_smooth_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_cong_ff   <= rsp_cong_in;
      rsp_strong_ff <= rsp_strong_in;
   end

   assign rsp_bus.valid                = rsp_valid_ff;
   assign rsp_bus.found                = rsp_found_ff;
   assign rsp_bus.raw_rssi             = rsp_raw_ff;
   assign rsp_bus.smoothed_rssi        = rsp_smooth_ff;
   assign rsp_bus.min_rssi             = rsp_min_ff;
   assign rsp_bus.max_rssi             = rsp_max_ff;
   assign rsp_bus.congestion_count     = rsp_cong_ff;
   assign rsp_bus.strongest_interferer = rsp_strong_ff;

endmodule

// ===== src/lnrt_checker.sv =====
`include "assert_macros.svh"

module lnrt_checker import lnrt_pkg::*; #(
   parameter int MAX_ENTRIES = 32
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_found,
   input level_type         rsp_raw_rssi,
   input level_type         rsp_smoothed_rssi,
   input level_type         rsp_min_rssi,
   input level_type         rsp_max_rssi,
   input logic [CONG_W-1:0] rsp_congestion_count,
   input level_type         rsp_strongest_interferer
);

   // No report may be pending right after reset.
   `LNRT_ASSERT_NORST(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "report valid after reset")

   // A stalled report stays offered.
   `LNRT_ASSERT_CLK(a_rsp_valid_holds, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "report dropped while stalled")

   // A stalled report keeps its contents.
   `LNRT_ASSERT_CLK(a_rsp_payload_holds, clock, reset, (rsp_valid && !rsp_ready) |=> ($stable(rsp_found) && $stable(rsp_raw_rssi) && $stable(rsp_smoothed_rssi) && $stable(rsp_min_rssi) && $stable(rsp_max_rssi) && $stable(rsp_congestion_count) && $stable(rsp_strongest_interferer)), "report changed while stalled")

   // Congestion can never exceed the per-scan entry limit.
   `LNRT_ASSERT_CLK(a_congestion_bound, clock, reset, rsp_valid |-> ({1'b0, rsp_congestion_count} <= 7'(MAX_ENTRIES)), "congestion count above entry limit")

endmodule

bind locked_network_rssi_tracker lnrt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_lnrt_checker (
   .clock                    (clock),
   .reset                    (reset),
   .rsp_valid                (rsp_bus.valid),
   .rsp_ready                (rsp_bus.ready),
   .rsp_found                (rsp_bus.found),
   .rsp_raw_rssi             (rsp_bus.raw_rssi),
   .rsp_smoothed_rssi        (rsp_bus.smoothed_rssi),
   .rsp_min_rssi             (rsp_bus.min_rssi),
   .rsp_max_rssi             (rsp_bus.max_rssi),
   .rsp_congestion_count     (rsp_bus.congestion_count),
   .rsp_strongest_interferer (rsp_bus.strongest_interferer)
);

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lnrt_pkg::*;

   localparam int WIN_DEPTH      = 8;
   localparam int SCAN_LIMIT     = 32;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_SHOWN      = 10;

   // Codes that the package leaves unnamed.
   localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
   localparam logic [REG_IDX_W-1:0] REG_UNUSED  = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   network_id;
      level_type         rssi;
      logic [CHAN_W-1:0] channel;
      logic              last_in_scan;
   } scan_req_t;

   typedef struct {
      logic              found;
      level_type         raw_rssi;
      level_type         smoothed_rssi;
      level_type         min_rssi;
      level_type         max_rssi;
      logic [CONG_W-1:0] congestion_count;
      level_type         strongest_interferer;
   } scan_report_t;

   // Tracks the block's state from accepted requests and holds the reports it owes.
   class scan_report_board;
      bit [0:0]        track_en;
      bit [ID_W-1:0]   target_id;
      bit [CHAN_W-1:0] start_chan;

      bit [CHAN_W-1:0] tracked_chan;
      bit              scan_found;
      int              scan_target;
      int              scan_cong;
      int              scan_strongest;
      int              scan_count;
      int              raw_lvl;
      int              smooth_lvl;
      int              min_lvl;
      int              max_lvl;
      int              window[WIN_DEPTH];
      int              win_idx;

      scan_report_t    pending_reports[$];
      int              failures;
      int              checked;
      int              found_reports;

      function new();
         track_en     = 1'b0;
         target_id    = '0;
         start_chan   = '0;
         tracked_chan = '0;
         failures     = 0;
         checked      = 0;
         found_reports = 0;
         clear_scan();
         clear_stats();
      endfunction

      function void clear_scan();
         scan_found     = 1'b0;
         scan_target    = int'(NO_SIGNAL);
         scan_cong      = 0;
         scan_strongest = int'(NO_SIGNAL);
         scan_count     = 0;
      endfunction

      function void clear_stats();
         raw_lvl    = int'(STAT_RESET);
         smooth_lvl = int'(STAT_RESET);
         min_lvl    = 0;
         max_lvl    = int'(STAT_RESET);
         foreach (window[i]) window[i] = 0;
         win_idx    = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_TRACK_EN:   track_en   = val[0];
            REG_TARGET_ID:  target_id  = val;
            REG_START_CHAN: start_chan = val[CHAN_W-1:0];
            default: ;
         endcase
      endfunction

      // Zero entries count as empty slots; the mean truncates toward zero.
      function int average_window(int v);
         int sum;
         int n;
         sum = 0;
         n = 0;
         window[win_idx] = v;
         win_idx = (win_idx + 1) % WIN_DEPTH;
         foreach (window[i]) begin
            if (window[i] != 0) begin
               sum += window[i];
               n++;
            end
         end
         return (n > 0) ? sum / n : v;
      endfunction

      function void close_scan();
         scan_report_t e;
         if (scan_found) begin
            raw_lvl = scan_target;
            smooth_lvl = average_window(scan_target);
            if (smooth_lvl < min_lvl || min_lvl == 0) min_lvl = smooth_lvl;
            if (smooth_lvl > max_lvl) max_lvl = smooth_lvl;
         end
         e.found                = scan_found;
         e.raw_rssi             = level_type'(raw_lvl);
         e.smoothed_rssi        = level_type'(smooth_lvl);
         e.min_rssi             = level_type'(min_lvl);
         e.max_rssi             = level_type'(max_lvl);
         e.congestion_count     = CONG_W'(scan_cong);
         e.strongest_interferer = level_type'(scan_strongest);
         pending_reports.push_back(e);
         clear_scan();
      endfunction

      function void note_request(scan_req_t r);
         int d;
         if (r.func == FUNC_RESTART) begin
            tracked_chan = start_chan;
            clear_stats();
            clear_scan();
            return;
         end
         if (r.func == FUNC_UNUSED) return;
         if (!track_en) begin
            clear_scan();
            return;
         end
         if (r.func == FUNC_SCAN_END) begin
            close_scan();
            return;
         end
         // Entries past the per-scan limit are dropped but may still end the scan.
         if (scan_count < SCAN_LIMIT) begin
            scan_count++;
            if (r.network_id == target_id) begin
               scan_found   = 1'b1;
               scan_target  = r.rssi;
               tracked_chan = r.channel;
            end
            if (tracked_chan != 0 && r.network_id != target_id) begin
               d = int'(r.channel) - int'(tracked_chan);
               if (d >= -OVERLAP_SPAN && d <= OVERLAP_SPAN) begin
                  if (scan_cong < int'(CONGEST_CAP)) scan_cong++;
                  if (int'(r.rssi) > scan_strongest) scan_strongest = r.rssi;
               end
            end
         end
         if (r.last_in_scan) close_scan();
      endfunction

      function string show(scan_report_t s);
         return $sformatf("found=%0b raw=%0d smooth=%0d min=%0d max=%0d cong=%0d strongest=%0d",
                          s.found, s.raw_rssi, s.smoothed_rssi, s.min_rssi, s.max_rssi,
                          s.congestion_count, s.strongest_interferer);
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= MAX_SHOWN) $display("ERROR: %s", msg);
      endfunction

      function void check_report(scan_report_t a);
         scan_report_t e;
         if (pending_reports.size() == 0) begin
            note_failure($sformatf("report with none pending: %s", show(a)));
            return;
         end
         e = pending_reports.pop_front();
         checked++;
         if (e.found === 1'b1) found_reports++;
         if (a.found !== e.found || a.raw_rssi !== e.raw_rssi ||
             a.smoothed_rssi !== e.smoothed_rssi || a.min_rssi !== e.min_rssi ||
             a.max_rssi !== e.max_rssi || a.congestion_count !== e.congestion_count ||
             a.strongest_interferer !== e.strongest_interferer) begin
            note_failure($sformatf("report %0d: expected %s, got %s", checked, show(e), show(a)));
         end
      endfunction

      function int outstanding();
         return pending_reports.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;

   lnrt_req_if req_bus();
   lnrt_rsp_if rsp_bus();
   lnrt_csr_if csr_bus();

   assign rsp_bus.ready = sink_ready;

   locked_network_rssi_tracker #(
      .WINDOW_LEN  (WIN_DEPTH),
      .MAX_ENTRIES (SCAN_LIMIT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   scan_report_board sb;
   scan_report_t     observed;
   int               send_idle_pct = 6;
   int               rcv_idle_pct  = 49;
   int               req_count     = 0;
   int               csr_count     = 0;
   int               quiet_cycles  = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The report receiver stalls at random.
   always @(negedge clock) begin
      sink_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Check every accepted report against the oldest pending one.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         observed.found                = rsp_bus.found;
         observed.raw_rssi             = rsp_bus.raw_rssi;
         observed.smoothed_rssi        = rsp_bus.smoothed_rssi;
         observed.min_rssi             = rsp_bus.min_rssi;
         observed.max_rssi             = rsp_bus.max_rssi;
         observed.congestion_count     = rsp_bus.congestion_count;
         observed.strongest_interferer = rsp_bus.strongest_interferer;
         sb.check_report(observed);
      end
   end

   // End the run if no channel moves anything for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic scan_req_t make_req(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                          level_type rssi, logic [CHAN_W-1:0] chan,
                                          logic last);
      scan_req_t r;
      r.func         = func;
      r.network_id   = id;
      r.rssi         = rssi;
      r.channel      = chan;
      r.last_in_scan = last;
      return r;
   endfunction

   function automatic level_type pick_rssi();
      int k;
      k = $urandom_range(9);
      if (k == 0) return level_type'(-128);
      if (k == 1) return level_type'(0);
      return level_type'(-int'($urandom_range(128)));
   endfunction

   // Mostly the target or unrelated ids, with the id extremes and near misses mixed in.
   function automatic logic [ID_W-1:0] pick_id();
      int k;
      k = $urandom_range(99);
      if (k < 35) return sb.target_id;
      if (k < 40) return '0;
      if (k < 45) return '1;
      if (k < 50) return sb.target_id ^ (32'h1 << $urandom_range(31));
      return $urandom;
   endfunction

   // A channel within three of the tracked one, clipped to the field range.
   function automatic logic [CHAN_W-1:0] nearby_channel();
      int c;
      c = int'(sb.tracked_chan) + int'($urandom_range(6)) - 3;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      return CHAN_W'(c);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_req(input scan_req_t r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= r.func;
      req_bus.network_id   <= r.network_id;
      req_bus.rssi         <= r.rssi;
      req_bus.channel      <= r.channel;
      req_bus.last_in_scan <= r.last_in_scan;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(r);
      req_count++;
      @(negedge clock);
   endtask

   // Hold requests until every pending report is in, then optionally let the block settle.
   task automatic drain(input bit settle);
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (sb.outstanding() != 0) @(negedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.write_reg(idx, val);
      csr_count++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // One scan of random content, ended by its last entry or by a scan-end request.
   task automatic random_scan();
      int len;
      bit end_by_cmd;
      logic [CHAN_W-1:0] ch;
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
      end_by_cmd = ($urandom_range(6) == 0);
      for (int i = 0; i < len; i++) begin
         ch = ($urandom_range(4) == 0) ? CHAN_W'($urandom) : nearby_channel();
         send_req(make_req(FUNC_ENTRY, pick_id(), pick_rssi(), ch,
                           !end_by_cmd && (i == len - 1)));
      end
      if (end_by_cmd) begin
         send_req(make_req(FUNC_SCAN_END, $urandom, pick_rssi(), CHAN_W'($urandom),
                           1'($urandom)));
      end
   endtask

   // Reprogram the block while it is idle, restart it, then run random traffic.
   task automatic run_phase(input bit en, input logic [ID_W-1:0] target,
                            input logic [CHAN_W-1:0] start, input int count);
      int stop_at;
      int k;
      drain(1'b1);
      write_csr(REG_TRACK_EN, {31'($urandom), en});
      write_csr(REG_TARGET_ID, target);
      write_csr(REG_START_CHAN, {24'($urandom), start});
      send_req(make_req(FUNC_RESTART, $urandom, pick_rssi(), CHAN_W'($urandom),
                        1'($urandom)));
      stop_at = req_count + count;
      while (req_count < stop_at) begin
         k = $urandom_range(99);
         if (k < 80) begin
            random_scan();
         end else if (k < 88) begin
            send_req(make_req(FUNC_RESTART, $urandom, pick_rssi(), CHAN_W'($urandom),
                              1'($urandom)));
         end else if (k < 92) begin
            send_req(make_req(FUNC_UNUSED, $urandom, pick_rssi(), CHAN_W'($urandom),
                              1'($urandom)));
         end else if (k < 96) begin
            send_req(make_req(FUNC_ENTRY, $urandom, pick_rssi(), CHAN_W'($urandom),
                              1'($urandom)));
         end else if (k < 98) begin
            send_req(make_req(FUNC_SCAN_END, $urandom, pick_rssi(), CHAN_W'($urandom),
                              1'($urandom)));
         end else begin
            drain(1'b0);
         end
      end
   endtask

   initial begin
      sb = new();
      req_bus.valid        = 1'b0;
      req_bus.func         = FUNC_ENTRY;
      req_bus.network_id   = '0;
      req_bus.rssi         = '0;
      req_bus.channel      = '0;
      req_bus.last_in_scan = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.addr         = REG_TRACK_EN;
      csr_bus.data         = '0;
      reset                = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Tracking is off after reset, so scans give no report.
      send_req(make_req(FUNC_ENTRY, 32'h0, -8'sd40, 8'd6, 1'b1));
      send_req(make_req(FUNC_SCAN_END, 32'h0, -8'sd1, 8'd0, 1'b0));
      drain(1'b1);
      write_csr(REG_TRACK_EN, 32'h1);
      write_csr(REG_TARGET_ID, 32'hFFFF_FFFF);
      write_csr(REG_START_CHAN, 32'h0);
      write_csr(REG_UNUSED, 32'hFFFF_FFFF);

      // An empty scan reports the reset statistics.
      send_req(make_req(FUNC_SCAN_END, 32'h1234_5678, -8'sd128, 8'd255, 1'b1));
      // With the channel unknown, nothing counts as congestion until the target is seen.
      send_req(make_req(FUNC_ENTRY, 32'h0, -8'sd30, 8'd1, 1'b0));
      send_req(make_req(FUNC_ENTRY, 32'hFFFF_FFFF, -8'sd128, 8'd1, 1'b0));
      send_req(make_req(FUNC_ENTRY, 32'h0000_0001, -8'sd1, 8'd3, 1'b0));
      send_req(make_req(FUNC_ENTRY, 32'h7FFF_FFFF, 8'sd0, 8'd0, 1'b0));
      send_req(make_req(FUNC_ENTRY, 32'h0000_0002, -8'sd5, 8'd4, 1'b0));
      send_req(make_req(FUNC_ENTRY, 32'hFFFF_FFFF, -8'sd60, 8'd2, 1'b1));
      // A zero reading is skipped by the average.
      send_req(make_req(FUNC_ENTRY, 32'hFFFF_FFFF, 8'sd0, 8'd255, 1'b1));
      send_req(make_req(FUNC_UNUSED, 32'hFFFF_FFFF, -8'sd1, 8'd255, 1'b1));
      // After a restart the window is empty, so a zero reading passes straight through.
      send_req(make_req(FUNC_RESTART, 32'hFFFF_FFFF, -8'sd1, 8'd255, 1'b1));
      send_req(make_req(FUNC_ENTRY, 32'hFFFF_FFFF, 8'sd0, 8'd0, 1'b1));
      send_req(make_req(FUNC_ENTRY, 32'hFFFF_FFFF, -8'sd128, 8'd255, 1'b0));
      send_req(make_req(FUNC_ENTRY, 32'h8000_0000, -8'sd128, 8'd254, 1'b0));
      send_req(make_req(FUNC_ENTRY, 32'hFFFF_FFFE, -8'sd77, 8'd253, 1'b1));
      send_req(make_req(FUNC_SCAN_END, 32'h0, 8'sd0, 8'd0, 1'b0));
      send_req(make_req(FUNC_RESTART, 32'h0, 8'sd0, 8'd0, 1'b0));

      // Sender idles lightly while the receiver stalls often.
      send_idle_pct = 6;
      rcv_idle_pct  = 49;
      run_phase(1'b1, $urandom, 8'd6, 110);
      run_phase(1'b1, 32'h0, 8'd1, 110);
      run_phase(1'b0, $urandom, 8'd11, 30);

      // Roles swapped.
      send_idle_pct = 49;
      rcv_idle_pct  = 6;
      run_phase(1'b1, 32'hFFFF_FFFF, 8'd255, 110);
      run_phase(1'b1, $urandom, 8'd0, 110);
      run_phase(1'b1, $urandom, 8'd128, 110);

      // Back to back on both sides.
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      run_phase(1'b1, 32'h0, 8'd254, 110);
      run_phase(1'b1, $urandom, 8'd2, 110);
      run_phase(1'b1, 32'hFFFF_FFFF, 8'd40, 110);

      drain(1'b1);
      $display("Sent %0d requests over nine register settings and %0d register writes.",
               req_count, csr_count);
      $display("Checked %0d scan reports, %0d with the target found; %0d failures.",
               sb.checked, sb.found_reports, sb.failures);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
